[rtl/dav_pkg.sv]
// Shared types and constants of the depth-aware view blend unit.
package dav_pkg;

	localparam int COLOR_BITS_DEF = 8;
	localparam int DEPTH_BITS_DEF = 8;

	localparam int TH_W       = 9;
	localparam int WEIGHT_W   = 16;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam int LANES       = 4;
	localparam int LANE_RED    = 0;
	localparam int LANE_GREEN  = 1;
	localparam int LANE_BLUE   = 2;
	localparam int LANE_DEPTH  = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [TH_W-1:0]     THRESHOLD_RST = 9'd5;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 16'd32768;
	localparam logic                INPAINT_RST   = 1'b0;

	typedef enum logic [1:0] {
		REG_THRESHOLD,
		REG_WEIGHT_LEFT,
		REG_WEIGHT_RIGHT,
		REG_INPAINT
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_HOLE,
		KIND_BLEND,
		KIND_COPY
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  depth_write;
	} cls_t;

	typedef struct packed {
		logic [TH_W-1:0]     threshold;
		logic [WEIGHT_W-1:0] weight_left;
		logic [WEIGHT_W-1:0] weight_right;
		logic                inpaint;
	} cfg_t;

endpackage

[rtl/dav_regs.sv]
// APB configuration registers of the view blend unit.
module dav_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dav_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [dav_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [dav_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output dav_pkg::cfg_t                    cfg
);

	dav_pkg::cfg_t     cfg_q;
	dav_pkg::reg_idx_t idx;

	assign idx    = dav_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= dav_pkg::THRESHOLD_RST;
			cfg_q.weight_left  <= dav_pkg::WEIGHT_RST;
			cfg_q.weight_right <= dav_pkg::WEIGHT_RST;
			cfg_q.inpaint      <= dav_pkg::INPAINT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				dav_pkg::REG_THRESHOLD:    cfg_q.threshold    <= pwdata[dav_pkg::TH_W-1:0];
				dav_pkg::REG_WEIGHT_LEFT:  cfg_q.weight_left  <= pwdata[dav_pkg::WEIGHT_W-1:0];
				dav_pkg::REG_WEIGHT_RIGHT: cfg_q.weight_right <= pwdata[dav_pkg::WEIGHT_W-1:0];
				dav_pkg::REG_INPAINT:      cfg_q.inpaint      <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			dav_pkg::REG_THRESHOLD:    prdata = dav_pkg::CFG_DATA_W'(cfg_q.threshold);
			dav_pkg::REG_WEIGHT_LEFT:  prdata = dav_pkg::CFG_DATA_W'(cfg_q.weight_left);
			dav_pkg::REG_WEIGHT_RIGHT: prdata = dav_pkg::CFG_DATA_W'(cfg_q.weight_right);
			dav_pkg::REG_INPAINT:      prdata = dav_pkg::CFG_DATA_W'(cfg_q.inpaint);
		endcase
	end

endmodule

[rtl/dav_front.sv]
// Front end: accepts pixels, classifies them and picks the copied view.
module dav_front #(
	parameter int COLOR_BITS = dav_pkg::COLOR_BITS_DEF,
	parameter int DEPTH_BITS = dav_pkg::DEPTH_BITS_DEF,
	parameter int ENTRY_W    = 3 + 2 * dav_pkg::LANES * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [dav_pkg::TH_W-1:0]  threshold,
	input  logic                      inpaint,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      hole,
	input  logic [COLOR_BITS-1:0]     left_red,
	input  logic [COLOR_BITS-1:0]     left_green,
	input  logic [COLOR_BITS-1:0]     left_blue,
	input  logic [COLOR_BITS-1:0]     right_red,
	input  logic [COLOR_BITS-1:0]     right_green,
	input  logic [COLOR_BITS-1:0]     right_blue,
	input  logic [DEPTH_BITS-1:0]     left_depth,
	input  logic [DEPTH_BITS-1:0]     right_depth,
	output logic                      push_valid,
	input  logic                      push_full,
	output logic [ENTRY_W-1:0]        push_data
);

	localparam int VW   = (COLOR_BITS > DEPTH_BITS) ? COLOR_BITS : DEPTH_BITS;
	localparam int CMPW = (DEPTH_BITS > dav_pkg::TH_W) ? DEPTH_BITS : dav_pkg::TH_W;

	typedef logic [dav_pkg::LANES-1:0][VW-1:0] lanes_t;

	logic [DEPTH_BITS-1:0] diff;
	logic                  close;
	logic                  left_wins;
	logic                  adv;
	lanes_t                la, lb, a_d;
	dav_pkg::cls_t         cls_d;

	logic                  valid_s1;
	dav_pkg::cls_t         cls_s1;
	lanes_t                a_s1, b_s1;

	always_comb begin
		la[dav_pkg::LANE_RED]   = VW'(left_red);
		la[dav_pkg::LANE_GREEN] = VW'(left_green);
		la[dav_pkg::LANE_BLUE]  = VW'(left_blue);
		la[dav_pkg::LANE_DEPTH] = VW'(left_depth);
		lb[dav_pkg::LANE_RED]   = VW'(right_red);
		lb[dav_pkg::LANE_GREEN] = VW'(right_green);
		lb[dav_pkg::LANE_BLUE]  = VW'(right_blue);
		lb[dav_pkg::LANE_DEPTH] = VW'(right_depth);

		left_wins = left_depth > right_depth;
		diff      = left_wins ? left_depth - right_depth : right_depth - left_depth;
		close     = CMPW'(diff) < CMPW'(threshold);

		if (hole) begin
			cls_d.kind = dav_pkg::KIND_HOLE;
		end else if (close) begin
			cls_d.kind = dav_pkg::KIND_BLEND;
		end else begin
			cls_d.kind = dav_pkg::KIND_COPY;
		end
		cls_d.depth_write = !hole && inpaint;

		a_d = (close || left_wins) ? la : lb;
	end

	assign adv        = !valid_s1 || !push_full;
	assign in_stall   = !adv;
	assign push_valid = valid_s1;
	assign push_data  = {cls_s1, a_s1, b_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			cls_s1 <= cls_d;
			a_s1   <= a_d;
			b_s1   <= lb;
		end
	end

endmodule

[rtl/dav_fifo.sv]
// Short transaction queue between the front end and the blend pipeline.
module dav_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dav_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             full,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_en, pop_en;

	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign push_en  = push_valid && !full;
	assign pop_en   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push_en) - CW'(pop_en);
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/dav_back.sv]
// Back end: weighted blend with a pipelined divider and the output register.
module dav_back #(
	parameter int COLOR_BITS = dav_pkg::COLOR_BITS_DEF,
	parameter int DEPTH_BITS = dav_pkg::DEPTH_BITS_DEF,
	parameter int ENTRY_W    = 3 + 2 * dav_pkg::LANES * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dav_pkg::WEIGHT_W-1:0]  weight_left,
	input  logic [dav_pkg::WEIGHT_W-1:0]  weight_right,
	output logic                          pop,
	input  logic                          empty,
	input  logic [ENTRY_W-1:0]            pop_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [COLOR_BITS-1:0]         out_red,
	output logic [COLOR_BITS-1:0]         out_green,
	output logic [COLOR_BITS-1:0]         out_blue,
	output logic [DEPTH_BITS-1:0]         out_depth,
	output logic                          depth_write
);

	localparam int VW    = (COLOR_BITS > DEPTH_BITS) ? COLOR_BITS : DEPTH_BITS;
	localparam int WW    = dav_pkg::WEIGHT_W;
	localparam int PRW   = VW + WW;
	localparam int NW    = PRW + 1;
	localparam int DNW   = WW + 1;
	localparam int L     = dav_pkg::LANES;
	localparam int CLS_W = $bits(dav_pkg::cls_t);

	typedef logic [L-1:0][VW-1:0]  lanes_t;
	typedef logic [L-1:0][PRW-1:0] prod_t;
	typedef logic [L-1:0][NW-1:0]  rem_t;

	dav_pkg::cls_t  cls_pop;
	lanes_t         a_pop, b_pop;
	logic           adv;
	logic [DNW-1:0] den;
	logic           den_zero;
	prod_t          pl_d, pr_d;

	logic           v_s1, v_s2;
	dav_pkg::cls_t  cls_s1, cls_s2;
	lanes_t         a_s1, a_s2;
	prod_t          pl_s1, pr_s1;
	rem_t           rem_s2;

	logic           v_s3   [VW];
	dav_pkg::cls_t  cls_s3 [VW];
	lanes_t         a_s3   [VW];
	rem_t           rem_s3 [VW];
	lanes_t         quo_s3 [VW];

	rem_t           rem_in [VW];
	lanes_t         quo_in [VW];
	rem_t           rem_nx [VW];
	lanes_t         quo_nx [VW];

	lanes_t         res_d;
	logic           out_valid_q;
	lanes_t         res_q;
	logic           dw_q;

	assign cls_pop  = dav_pkg::cls_t'(pop_data[ENTRY_W-1 -: CLS_W]);
	assign a_pop    = lanes_t'(pop_data[2*L*VW-1 -: L*VW]);
	assign b_pop    = lanes_t'(pop_data[L*VW-1:0]);
	assign adv      = !out_valid_q || !out_stall;
	assign pop      = !empty && adv;
	assign den      = DNW'(weight_left) + DNW'(weight_right);
	assign den_zero = den == '0;

	always_comb begin
		for (int i = 0; i < L; i++) begin
			pl_d[i] = PRW'(a_pop[i]) * PRW'(weight_left);
			pr_d[i] = PRW'(b_pop[i]) * PRW'(weight_right);
		end
	end

	always_comb begin
		rem_in[0] = rem_s2;
		quo_in[0] = '0;
		for (int k = 1; k < VW; k++) begin
			rem_in[k] = rem_s3[k-1];
			quo_in[k] = quo_s3[k-1];
		end
		for (int k = 0; k < VW; k++) begin
			for (int i = 0; i < L; i++) begin
				if (rem_in[k][i] >= (NW'(den) << (VW - 1 - k))) begin
					rem_nx[k][i] = rem_in[k][i] - (NW'(den) << (VW - 1 - k));
					quo_nx[k][i] = quo_in[k][i] | (VW'(1) << (VW - 1 - k));
				end else begin
					rem_nx[k][i] = rem_in[k][i];
					quo_nx[k][i] = quo_in[k][i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < L; i++) begin
			unique case (cls_s3[VW-1].kind)
				dav_pkg::KIND_HOLE:  res_d[i] = '0;
				dav_pkg::KIND_BLEND: res_d[i] = den_zero ? a_s3[VW-1][i] : quo_s3[VW-1][i];
				dav_pkg::KIND_COPY:  res_d[i] = a_s3[VW-1][i];
				default:             res_d[i] = '0;
			endcase
		end
		if (!cls_s3[VW-1].depth_write) begin
			res_d[dav_pkg::LANE_DEPTH] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < VW; k++) begin
				v_s3[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3[0] <= v_s2;
			for (int k = 1; k < VW; k++) begin
				v_s3[k] <= v_s3[k-1];
			end
			out_valid_q <= v_s3[VW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1 <= cls_pop;
			a_s1   <= a_pop;
			pl_s1  <= pl_d;
			pr_s1  <= pr_d;

			cls_s2 <= cls_s1;
			a_s2   <= a_s1;
			for (int i = 0; i < L; i++) begin
				rem_s2[i] <= NW'(pl_s1[i]) + NW'(pr_s1[i]);
			end

			cls_s3[0] <= cls_s2;
			a_s3[0]   <= a_s2;
			for (int k = 1; k < VW; k++) begin
				cls_s3[k] <= cls_s3[k-1];
				a_s3[k]   <= a_s3[k-1];
			end
			for (int k = 0; k < VW; k++) begin
				rem_s3[k] <= rem_nx[k];
				quo_s3[k] <= quo_nx[k];
			end

			res_q <= res_d;
			dw_q  <= cls_s3[VW-1].depth_write;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = res_q[dav_pkg::LANE_RED][COLOR_BITS-1:0];
	assign out_green   = res_q[dav_pkg::LANE_GREEN][COLOR_BITS-1:0];
	assign out_blue    = res_q[dav_pkg::LANE_BLUE][COLOR_BITS-1:0];
	assign out_depth   = res_q[dav_pkg::LANE_DEPTH][DEPTH_BITS-1:0];
	assign depth_write = dw_q;

endmodule

[rtl/depth_aware_view_blend_unit.sv]
// Path: front register, queue, product and sum registers, divider, output register,
// where VW = max(COLOR_BITS, DEPTH_BITS); VW is the number of divider stages.
// Throughput: one transaction per cycle while out_stall is low; the divider resolves
// one quotient bit per stage and all stages advance together.
// Reset: arst_n clears all valid bits and the queue and loads the register defaults.
module depth_aware_view_blend_unit #(
	parameter int COLOR_BITS = dav_pkg::COLOR_BITS_DEF,
	parameter int DEPTH_BITS = dav_pkg::DEPTH_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dav_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [dav_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [dav_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             hole,
	input  logic [COLOR_BITS-1:0]            left_red,
	input  logic [COLOR_BITS-1:0]            left_green,
	input  logic [COLOR_BITS-1:0]            left_blue,
	input  logic [COLOR_BITS-1:0]            right_red,
	input  logic [COLOR_BITS-1:0]            right_green,
	input  logic [COLOR_BITS-1:0]            right_blue,
	input  logic [DEPTH_BITS-1:0]            left_depth,
	input  logic [DEPTH_BITS-1:0]            right_depth,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [COLOR_BITS-1:0]            out_red,
	output logic [COLOR_BITS-1:0]            out_green,
	output logic [COLOR_BITS-1:0]            out_blue,
	output logic [DEPTH_BITS-1:0]            out_depth,
	output logic                             depth_write
);

	localparam int VW      = (COLOR_BITS > DEPTH_BITS) ? COLOR_BITS : DEPTH_BITS;
	localparam int ENTRY_W = $bits(dav_pkg::cls_t) + 2 * dav_pkg::LANES * VW;

	dav_pkg::cfg_t      cfg;
	logic               push_valid, full, pop, empty;
	logic [ENTRY_W-1:0] push_data, pop_data;

	dav_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dav_front #(
		.COLOR_BITS (COLOR_BITS),
		.DEPTH_BITS (DEPTH_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.threshold   (cfg.threshold),
		.inpaint     (cfg.inpaint),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.hole        (hole),
		.left_red    (left_red),
		.left_green  (left_green),
		.left_blue   (left_blue),
		.right_red   (right_red),
		.right_green (right_green),
		.right_blue  (right_blue),
		.left_depth  (left_depth),
		.right_depth (right_depth),
		.push_valid  (push_valid),
		.push_full   (full),
		.push_data   (push_data)
	);

	dav_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (dav_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.full       (full),
		.push_data  (push_data),
		.pop        (pop),
		.empty      (empty),
		.pop_data   (pop_data)
	);

	dav_back #(
		.COLOR_BITS (COLOR_BITS),
		.DEPTH_BITS (DEPTH_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.weight_left  (cfg.weight_left),
		.weight_right (cfg.weight_right),
		.pop          (pop),
		.empty        (empty),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_depth    (out_depth),
		.depth_write  (depth_write)
	);

endmodule
